>>> rtl/dptfl_pkg.sv
package dptfl_pkg;

	localparam int PAGE_ENTRIES = 256;
	localparam int FRAME_SLOTS  = 64;

	localparam int ADDR_W  = 24;
	localparam int PAGE_W  = 8;
	localparam int FRAME_W = 6;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int PA_W    = 22;
	localparam int OFF_W   = 16;
	localparam int SHIFT_W = 5;
	localparam int FCNT_W  = 7;
	localparam int CFG_W   = 7;
	localparam int IDX_W   = 2;
	localparam int SCAN_W  = PAGE_W + 1;

	localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd4;
	localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
	localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
	localparam logic [FCNT_W-1:0]  FRAMES_MIN = 7'd1;
	localparam logic [FCNT_W-1:0]  FRAMES_MAX = FCNT_W'(FRAME_SLOTS);

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	localparam logic [IDX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [IDX_W-1:0] REG_SHIFT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAMES = 2'd2;

	typedef struct packed {
		logic clr;
		logic en;
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [PAGE_W-1:0] victim;
	} scan_res_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == '1) ? v : v + 32'd1;
	endfunction

endpackage

>>> rtl/demand_paging_table_fifo_lru_top.sv
// result path by state: out of range or on a free-frame fault S_CHECK then S_FINISH, on a
// hit S_CHECK, S_HREAD, S_FINISH, on a fault with all frames used S_CHECK, S_SCAN, S_VREAD,
// S_VWAIT, S_FINISH; a new transaction is taken only in S_IDLE; the full-frame fault runs the
// victim scan that reads every page entry's stamp once through one stamp memory's read port
// a new transaction is taken while the last result waits for out_ready
// reset: page valid flip-flops, counters and clock clear at once, no clearing pass
module demand_paging_table_fifo_lru_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dptfl_pkg::IDX_W-1:0]     cfg_index,
	input  logic [dptfl_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dptfl_pkg::ADDR_W-1:0]    virt_addr,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            hit,
	output logic                            out_of_range,
	output logic [dptfl_pkg::FRAME_W-1:0]   frame_index,
	output logic [dptfl_pkg::PA_W-1:0]      phys_addr,
	output logic                            evicted,
	output logic [dptfl_pkg::PAGE_W-1:0]    evicted_page,
	output logic [dptfl_pkg::CNT_W-1:0]     hit_total,
	output logic [dptfl_pkg::CNT_W-1:0]     fault_total
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_HREAD,
		S_SCAN,
		S_VREAD,
		S_VWAIT,
		S_FINISH
	} state_t;

	state_t state_q;

	logic                            policy_q;
	logic [dptfl_pkg::SHIFT_W-1:0]   shift_q;
	logic [dptfl_pkg::FCNT_W-1:0]    frames_q;

	logic [dptfl_pkg::SHIFT_W-1:0]   sh_c;
	logic [dptfl_pkg::FCNT_W-1:0]    frames_c;
	logic [dptfl_pkg::ADDR_W-1:0]    page_full_c;
	logic [dptfl_pkg::ADDR_W-1:0]    offset_c;

	logic [dptfl_pkg::SHIFT_W-1:0]   sh_q;
	logic [dptfl_pkg::FCNT_W-1:0]    lim_q;
	logic [dptfl_pkg::PAGE_W-1:0]    page_q;
	logic [dptfl_pkg::OFF_W-1:0]     offset_q;
	logic                            oor_q;

	logic                            page_valid_q [dptfl_pkg::PAGE_ENTRIES];
	logic [dptfl_pkg::STAMP_W-1:0]   clock_q;
	logic [dptfl_pkg::STAMP_W-1:0]   clock_next_c;
	logic [dptfl_pkg::FCNT_W-1:0]    free_next_q;
	logic [dptfl_pkg::CNT_W-1:0]     hit_cnt_q;
	logic [dptfl_pkg::CNT_W-1:0]     fault_cnt_q;

	logic [dptfl_pkg::SCAN_W-1:0]    scan_idx_q;
	logic                            pipe_v_s1;
	logic                            pipe_ok_s1;
	logic [dptfl_pkg::PAGE_W-1:0]    pipe_idx_s1;

	logic                            res_hit_q;
	logic [dptfl_pkg::FRAME_W-1:0]   res_frame_q;
	logic                            res_evicted_q;
	logic [dptfl_pkg::PAGE_W-1:0]    res_evpage_q;

	logic                            free_ok_c;
	logic                            check_hit_c;
	logic                            check_free_c;

	logic                            frame_we;
	logic [dptfl_pkg::FRAME_W-1:0]   frame_wdata;
	logic [dptfl_pkg::PAGE_W-1:0]    frame_raddr;
	logic [dptfl_pkg::FRAME_W-1:0]   frame_rdata;
	logic                            load_we;
	logic                            use_we;
	logic [dptfl_pkg::STAMP_W-1:0]   stamp_wdata;
	logic [dptfl_pkg::STAMP_W-1:0]   load_rdata;
	logic [dptfl_pkg::STAMP_W-1:0]   use_rdata;
	logic [dptfl_pkg::STAMP_W-1:0]   scan_stamp;

	dptfl_pkg::scan_ctl_t            scan_ctl;
	dptfl_pkg::scan_res_t            scan_res;

	logic [dptfl_pkg::PA_W-1:0]      phys_c;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= dptfl_pkg::POLICY_FIFO;
			shift_q  <= dptfl_pkg::SHIFT_RST;
			frames_q <= dptfl_pkg::FRAMES_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				dptfl_pkg::REG_POLICY: policy_q <= cfg_data[0];
				dptfl_pkg::REG_SHIFT:  shift_q  <= cfg_data[dptfl_pkg::SHIFT_W-1:0];
				dptfl_pkg::REG_FRAMES: frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (shift_q < dptfl_pkg::SHIFT_MIN) begin
			sh_c = dptfl_pkg::SHIFT_MIN;
		end else if (shift_q > dptfl_pkg::SHIFT_MAX) begin
			sh_c = dptfl_pkg::SHIFT_MAX;
		end else begin
			sh_c = shift_q;
		end
		if (frames_q < dptfl_pkg::FRAMES_MIN) begin
			frames_c = dptfl_pkg::FRAMES_MIN;
		end else if (frames_q > dptfl_pkg::FRAMES_MAX) begin
			frames_c = dptfl_pkg::FRAMES_MAX;
		end else begin
			frames_c = frames_q;
		end
	end

	assign page_full_c  = virt_addr >> sh_c;
	assign offset_c     = virt_addr & ((dptfl_pkg::ADDR_W'(1) << sh_c) - dptfl_pkg::ADDR_W'(1));
	assign clock_next_c = dptfl_pkg::sat_inc(clock_q);

	assign in_ready     = (state_q == S_IDLE);
	assign free_ok_c    = (free_next_q < lim_q);
	assign check_hit_c  = (state_q == S_CHECK) && !oor_q && page_valid_q[page_q];
	assign check_free_c = (state_q == S_CHECK) && !oor_q && !page_valid_q[page_q] && free_ok_c;

	// table memories
	assign frame_we    = check_free_c || (state_q == S_VWAIT);
	assign frame_wdata = (state_q == S_VWAIT) ? (scan_res.found ? frame_rdata : '0)
	                                          : free_next_q[dptfl_pkg::FRAME_W-1:0];
	assign frame_raddr = (state_q == S_CHECK) ? page_q : scan_res.victim;
	assign load_we     = frame_we;
	assign use_we      = frame_we || check_hit_c;
	assign stamp_wdata = (state_q == S_CHECK) ? clock_next_c : clock_q;

	dptfl_ram #(.WIDTH(dptfl_pkg::FRAME_W), .DEPTH(dptfl_pkg::PAGE_ENTRIES)) u_frame_ram (
		.clk   (clk),
		.we    (frame_we),
		.waddr (page_q),
		.wdata (frame_wdata),
		.raddr (frame_raddr),
		.rdata (frame_rdata)
	);

	dptfl_ram #(.WIDTH(dptfl_pkg::STAMP_W), .DEPTH(dptfl_pkg::PAGE_ENTRIES)) u_load_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (page_q),
		.wdata (stamp_wdata),
		.raddr (scan_idx_q[dptfl_pkg::PAGE_W-1:0]),
		.rdata (load_rdata)
	);

	dptfl_ram #(.WIDTH(dptfl_pkg::STAMP_W), .DEPTH(dptfl_pkg::PAGE_ENTRIES)) u_use_ram (
		.clk   (clk),
		.we    (use_we),
		.waddr (page_q),
		.wdata (stamp_wdata),
		.raddr (scan_idx_q[dptfl_pkg::PAGE_W-1:0]),
		.rdata (use_rdata)
	);

	// victim search
	assign scan_stamp   = (policy_q == dptfl_pkg::POLICY_LRU) ? use_rdata : load_rdata;
	assign scan_ctl.clr = (state_q == S_CHECK);
	assign scan_ctl.en  = (state_q == S_SCAN) && pipe_v_s1 && pipe_ok_s1;

	dptfl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.stamp  (scan_stamp),
		.index  (pipe_idx_s1),
		.res    (scan_res)
	);

	assign phys_c = oor_q ? '0
	              : ((dptfl_pkg::PA_W'(res_frame_q) << sh_q) | dptfl_pkg::PA_W'(offset_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			for (int i = 0; i < dptfl_pkg::PAGE_ENTRIES; i++) begin
				page_valid_q[i] <= 1'b0;
			end
			clock_q     <= '0;
			free_next_q <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			scan_idx_q  <= '0;
			pipe_v_s1   <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_FINISH) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sh_q     <= sh_c;
						lim_q    <= frames_c;
						page_q   <= page_full_c[dptfl_pkg::PAGE_W-1:0];
						offset_q <= offset_c[dptfl_pkg::OFF_W-1:0];
						oor_q    <= (page_full_c[dptfl_pkg::ADDR_W-1:dptfl_pkg::PAGE_W] != '0);
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					res_evicted_q <= 1'b0;
					res_evpage_q  <= '0;
					scan_idx_q    <= '0;
					pipe_v_s1     <= 1'b0;
					if (oor_q) begin
						res_hit_q   <= 1'b0;
						res_frame_q <= '0;
						state_q     <= S_FINISH;
					end else begin
						clock_q <= clock_next_c;
						if (page_valid_q[page_q]) begin
							res_hit_q <= 1'b1;
							hit_cnt_q <= dptfl_pkg::sat_inc(hit_cnt_q);
							state_q   <= S_HREAD;
						end else begin
							res_hit_q   <= 1'b0;
							fault_cnt_q <= dptfl_pkg::sat_inc(fault_cnt_q);
							if (free_ok_c) begin
								page_valid_q[page_q] <= 1'b1;
								res_frame_q <= free_next_q[dptfl_pkg::FRAME_W-1:0];
								free_next_q <= free_next_q + dptfl_pkg::FCNT_W'(1);
								state_q     <= S_FINISH;
							end else begin
								res_frame_q <= '0;
								state_q     <= S_SCAN;
							end
						end
					end
				end
				S_HREAD: begin
					res_frame_q <= frame_rdata;
					state_q     <= S_FINISH;
				end
				S_SCAN: begin
					if (!scan_idx_q[dptfl_pkg::PAGE_W]) begin
						pipe_v_s1   <= 1'b1;
						pipe_ok_s1  <= page_valid_q[scan_idx_q[dptfl_pkg::PAGE_W-1:0]];
						pipe_idx_s1 <= scan_idx_q[dptfl_pkg::PAGE_W-1:0];
						scan_idx_q  <= scan_idx_q + dptfl_pkg::SCAN_W'(1);
					end else begin
						pipe_v_s1 <= 1'b0;
						if (!pipe_v_s1) begin
							state_q <= S_VREAD;
						end
					end
				end
				S_VREAD: begin
					state_q <= S_VWAIT;
				end
				S_VWAIT: begin
					page_valid_q[page_q] <= 1'b1;
					if (scan_res.found) begin
						page_valid_q[scan_res.victim] <= 1'b0;
						res_frame_q   <= frame_rdata;
						res_evicted_q <= 1'b1;
						res_evpage_q  <= scan_res.victim;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						hit          <= res_hit_q;
						out_of_range <= oor_q;
						frame_index  <= res_frame_q;
						phys_addr    <= phys_c;
						evicted      <= res_evicted_q;
						evicted_page <= res_evpage_q;
						hit_total    <= hit_cnt_q;
						fault_total  <= fault_cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/dptfl_ram.sv
module dptfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/dptfl_scan.sv
module dptfl_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dptfl_pkg::scan_ctl_t                ctl,
	input  logic [dptfl_pkg::STAMP_W-1:0]       stamp,
	input  logic [dptfl_pkg::PAGE_W-1:0]        index,
	output dptfl_pkg::scan_res_t                res
);

	logic                          found_q;
	logic [dptfl_pkg::STAMP_W-1:0] best_q;
	logic [dptfl_pkg::PAGE_W-1:0]  victim_q;

	// strict compare keeps the lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clr) begin
			found_q <= 1'b0;
		end else if (ctl.en && (!found_q || stamp < best_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.en && (!found_q || stamp < best_q)) begin
			best_q   <= stamp;
			victim_q <= index;
		end
	end

	assign res.found  = found_q;
	assign res.victim = victim_q;

endmodule
